>>> sv/dbba_pkg.sv
// Shared types, codes and constants for the disk block bitmap allocator.
`timescale 1ns / 1ps

package dbba_pkg;

    // Default disk geometry
    localparam int CYLINDERS_DEF         = 8;
    localparam int TRACKS_PER_CYL_DEF    = 2;
    localparam int SECTORS_PER_TRACK_DEF = 4;

    // Fixed beat field widths
    localparam int OPCODE_W  = 2;
    localparam int CYL_W     = 3;
    localparam int TRACK_W   = 1;
    localparam int SECTOR_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int BITNUM_W  = 3;
    localparam int ROWOUT_W  = 8;

    // Holds sectors * track + sector for the largest geometry (64 * 1 + 3)
    localparam int BIT_POS_W = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_MARK  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EVAL
    } back_state_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                  op;
        logic [CYL_W-1:0]     cyl;
        logic [TRACK_W-1:0]   track;
        logic [SECTOR_W-1:0]  sector;
        logic                 addr_ok;
        logic                 cyl_ok;
        logic [BIT_POS_W-1:0] bit_pos;
    } cmd_t;

endpackage

>>> sv/dbba_if.sv
// Request and response channel interfaces of the bitmap allocator.
`timescale 1ns / 1ps

interface dbba_req_if;
    logic                          valid;
    logic                          ready;
    logic [dbba_pkg::OPCODE_W-1:0] opcode;
    logic [dbba_pkg::CYL_W-1:0]    cyl_in;
    logic [dbba_pkg::TRACK_W-1:0]  track_in;
    logic [dbba_pkg::SECTOR_W-1:0] sector_in;

    modport source (output valid, opcode, cyl_in, track_in, sector_in, input ready);
    modport sink   (input valid, opcode, cyl_in, track_in, sector_in, output ready);
endinterface

interface dbba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dbba_pkg::STATUS_W-1:0] status;
    logic [dbba_pkg::CYL_W-1:0]    cyl_out;
    logic [dbba_pkg::TRACK_W-1:0]  track_out;
    logic [dbba_pkg::SECTOR_W-1:0] sector_out;
    logic [dbba_pkg::BITNUM_W-1:0] bit_number;
    logic [dbba_pkg::ROWOUT_W-1:0] row_bits;

    modport source (output valid, status, cyl_out, track_out, sector_out, bit_number,
                    row_bits, input ready);
    modport sink   (input valid, status, cyl_out, track_out, sector_out, bit_number,
                    row_bits, output ready);
endinterface

>>> sv/disk_block_bitmap_allocator_unit.sv
// Top level of the first-fit disk block bitmap allocator.
// Sequence: each command passes through the accept cycle, the registered row read and the
//   evaluate and write-back cycle; allocate scans a row a cycle, passing over at most
//   CYLINDERS - 1 rows (7 by default). A new command is taken only once the last one has
//   posted its response beat.
// Reset: every row flag clears at once so the whole map reads free; no clearing pass.
`timescale 1ns / 1ps

module disk_block_bitmap_allocator_unit #(
    parameter int CYLINDERS         = dbba_pkg::CYLINDERS_DEF,
    parameter int TRACKS_PER_CYL    = dbba_pkg::TRACKS_PER_CYL_DEF,
    parameter int SECTORS_PER_TRACK = dbba_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dbba_req_if.sink    req,
    dbba_rsp_if.source  rsp
);

    // Front to queue
    logic            push_valid;
    logic            push_ready;
    dbba_pkg::cmd_t  push_cmd;

    // Queue to back
    logic            pop_valid;
    logic            pop_ready;
    dbba_pkg::cmd_t  pop_cmd;

    // Classify each request beat: range-check the address, form the bit position in its row.
    // The request side stalls only when the queue is full.
    dbba_front #(
        .CYLINDERS         (CYLINDERS),
        .TRACKS_PER_CYL    (TRACKS_PER_CYL),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Hold classified commands so the front keeps taking beats while a scan runs
    dbba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Carry out each command against the row memory; the response register lets a finished
    // beat wait for the sink while the sequencer stalls only when it has a new one to post.
    dbba_back #(
        .CYLINDERS         (CYLINDERS),
        .TRACKS_PER_CYL    (TRACKS_PER_CYL),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

>>> sv/dbba_front.sv
// Front end: accept request beats, range-check the address and form the row bit position.
`timescale 1ns / 1ps

module dbba_front #(
    parameter int CYLINDERS         = dbba_pkg::CYLINDERS_DEF,
    parameter int TRACKS_PER_CYL    = dbba_pkg::TRACKS_PER_CYL_DEF,
    parameter int SECTORS_PER_TRACK = dbba_pkg::SECTORS_PER_TRACK_DEF
) (
    dbba_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output dbba_pkg::cmd_t  push_cmd
);

    logic cyl_ok;
    logic trk_ok;
    logic sec_ok;

    always_comb
    begin
        cyl_ok = 32'(req.cyl_in) < 32'(CYLINDERS);
        trk_ok = 32'(req.track_in) < 32'(TRACKS_PER_CYL);
        sec_ok = 32'(req.sector_in) < 32'(SECTORS_PER_TRACK);

        push_cmd.op      = dbba_pkg::op_t'(req.opcode);
        push_cmd.cyl     = req.cyl_in;
        push_cmd.track   = req.track_in;
        push_cmd.sector  = req.sector_in;
        push_cmd.cyl_ok  = cyl_ok;
        push_cmd.addr_ok = cyl_ok && trk_ok && sec_ok;
        push_cmd.bit_pos = dbba_pkg::BIT_POS_W'(32'(SECTORS_PER_TRACK) * 32'(req.track_in)
                                                + 32'(req.sector_in));
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

>>> sv/dbba_queue.sv
// Short command queue decoupling the front end from the bitmap sequencer.
`timescale 1ns / 1ps

module dbba_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  dbba_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output dbba_pkg::cmd_t  pop_cmd
);

    dbba_pkg::cmd_t                         entry_reg [dbba_pkg::QUEUE_DEPTH];
    logic [dbba_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [dbba_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [dbba_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [dbba_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [dbba_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [dbba_pkg::QUEUE_CNT_W-1:0]       count_next;
    logic                                   do_push;
    logic                                   do_pop;

    assign push_ready = count_reg != dbba_pkg::QUEUE_CNT_W'(dbba_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == dbba_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == dbba_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/dbba_back.sv
// Back end: bitmap row memory, first-fit scan sequencer and response register.
`timescale 1ns / 1ps

module dbba_back #(
    parameter int CYLINDERS         = dbba_pkg::CYLINDERS_DEF,
    parameter int TRACKS_PER_CYL    = dbba_pkg::TRACKS_PER_CYL_DEF,
    parameter int SECTORS_PER_TRACK = dbba_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  dbba_pkg::cmd_t  pop_cmd,
    dbba_rsp_if.source      rsp
);

    localparam int ROW_BITS = TRACKS_PER_CYL * SECTORS_PER_TRACK;
    localparam int ROW_AW   = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int TRK_IW   = (TRACKS_PER_CYL > 1) ? $clog2(TRACKS_PER_CYL) : 1;
    localparam int SEC_IW   = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
    localparam int BIT_POS_W_LOCAL = dbba_pkg::BIT_POS_W;

    // Row memory; valid flags make a never-written row read as all free
    logic [ROW_BITS-1:0]              mem [CYLINDERS];
    logic [CYLINDERS-1:0]             row_valid_reg;
    logic [ROW_BITS-1:0]              rd_data_reg;
    logic                             rd_valid_reg;

    dbba_pkg::back_state_t            state_reg;
    dbba_pkg::back_state_t            state_next;
    dbba_pkg::cmd_t                   cmd_reg;
    logic [ROW_AW-1:0]                scan_reg;
    logic [ROW_AW-1:0]                scan_next;

    logic [ROW_AW-1:0]                rd_addr;
    logic                             wr_en;
    logic [ROW_AW-1:0]                wr_addr;
    logic [ROW_BITS-1:0]              wr_data;
    logic                             done;
    logic                             out_free;
    logic                             scan_last;

    logic [ROW_BITS-1:0]              row_eff;
    logic [ROW_BITS-1:0]              free_bits;
    logic [ROW_BITS-1:0]              bit_mask;
    logic [ROW_BITS-1:0]              alloc_mask;
    logic [TRACKS_PER_CYL-1:0]        trk_free;
    logic [SECTORS_PER_TRACK-1:0]     sec_free;
    logic [TRK_IW-1:0]                first_trk;
    logic [SEC_IW-1:0]                first_sec;
    logic [BIT_POS_W_LOCAL-1:0]       first_bit;
    logic                             row_has_free;
    logic                             blk_used;
    logic [ROW_AW-1:0]                cmd_row;

    logic                             out_valid_reg;
    dbba_pkg::status_t                status_reg;
    logic [dbba_pkg::CYL_W-1:0]       cyl_out_reg;
    logic [dbba_pkg::TRACK_W-1:0]     track_out_reg;
    logic [dbba_pkg::SECTOR_W-1:0]    sector_out_reg;
    logic [dbba_pkg::BITNUM_W-1:0]    bit_number_reg;
    logic [dbba_pkg::ROWOUT_W-1:0]    row_bits_reg;

    dbba_pkg::status_t                res_status;
    logic [dbba_pkg::CYL_W-1:0]       res_cyl;
    logic [dbba_pkg::TRACK_W-1:0]     res_track;
    logic [dbba_pkg::SECTOR_W-1:0]    res_sector;
    logic [dbba_pkg::BITNUM_W-1:0]    res_bit;
    logic [dbba_pkg::ROWOUT_W-1:0]    res_row;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_row   = ROW_AW'(cmd_reg.cyl);
    assign scan_last = 32'(scan_reg) == CYLINDERS - 1;

    // Row as seen after the registered read
    assign row_eff   = rd_valid_reg ? rd_data_reg : '0;
    assign free_bits = ~row_eff;
    assign bit_mask  = cmd_reg.addr_ok ? (ROW_BITS'(1) << cmd_reg.bit_pos) : '0;
    assign blk_used  = |(row_eff & bit_mask);

    // First free block: lowest track with a free sector, then lowest sector
    always_comb
    begin
        for (int t = 0; t < TRACKS_PER_CYL; t++)
        begin
            trk_free[t] = |free_bits[t*SECTORS_PER_TRACK +: SECTORS_PER_TRACK];
        end
        row_has_free = |trk_free;
        first_trk = '0;
        for (int t = TRACKS_PER_CYL - 1; t >= 0; t--)
        begin
            if (trk_free[t])
            begin
                first_trk = TRK_IW'(t);
            end
        end
        sec_free  = free_bits[32'(first_trk)*SECTORS_PER_TRACK +: SECTORS_PER_TRACK];
        first_sec = '0;
        for (int s = SECTORS_PER_TRACK - 1; s >= 0; s--)
        begin
            if (sec_free[s])
            begin
                first_sec = SEC_IW'(s);
            end
        end
        first_bit  = BIT_POS_W_LOCAL'(32'(first_trk) * SECTORS_PER_TRACK + 32'(first_sec));
        alloc_mask = ROW_BITS'(1) << first_bit;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dbba_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = dbba_pkg::B_READ;
                end
            end
            dbba_pkg::B_READ:
            begin
                state_next = dbba_pkg::B_EVAL;
            end
            dbba_pkg::B_EVAL:
            begin
                if (done)
                begin
                    state_next = dbba_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dbba_pkg::B_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory port, scan advance and response
    always_comb
    begin
        pop_ready  = 1'b0;
        rd_addr    = cmd_row;
        wr_en      = 1'b0;
        wr_addr    = cmd_row;
        wr_data    = row_eff;
        done       = 1'b0;
        scan_next  = scan_reg;
        res_status = dbba_pkg::ST_OK;
        res_cyl    = cmd_reg.cyl;
        res_track  = cmd_reg.track;
        res_sector = cmd_reg.sector;
        res_bit    = dbba_pkg::BITNUM_W'(cmd_reg.bit_pos);
        res_row    = '0;
        case (state_reg)
            dbba_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                scan_next = '0;
            end
            dbba_pkg::B_READ:
            begin
                if (cmd_reg.op == dbba_pkg::OP_ALLOC)
                begin
                    rd_addr = scan_reg;
                end
            end
            dbba_pkg::B_EVAL:
            begin
                case (cmd_reg.op)
                    dbba_pkg::OP_MARK:
                    begin
                        done    = out_free;
                        wr_en   = out_free && cmd_reg.addr_ok;
                        wr_data = row_eff | bit_mask;
                    end
                    dbba_pkg::OP_ALLOC:
                    begin
                        rd_addr    = scan_reg;
                        wr_addr    = scan_reg;
                        wr_data    = row_eff | alloc_mask;
                        res_cyl    = dbba_pkg::CYL_W'(scan_reg);
                        res_track  = dbba_pkg::TRACK_W'(first_trk);
                        res_sector = dbba_pkg::SECTOR_W'(first_sec);
                        res_bit    = dbba_pkg::BITNUM_W'(first_bit);
                        if (row_has_free)
                        begin
                            done  = out_free;
                            wr_en = out_free;
                        end
                        else if (!scan_last)
                        begin
                            scan_next = scan_reg + 1'b1;
                            rd_addr   = scan_reg + 1'b1;
                        end
                        else
                        begin
                            done       = out_free;
                            res_status = dbba_pkg::ST_NO_FREE;
                            res_cyl    = '0;
                            res_track  = '0;
                            res_sector = '0;
                            res_bit    = '0;
                        end
                    end
                    dbba_pkg::OP_FREE:
                    begin
                        done    = out_free;
                        wr_en   = out_free && blk_used;
                        wr_data = row_eff & ~bit_mask;
                        if (!blk_used)
                        begin
                            res_status = dbba_pkg::ST_NOT_ALLOC;
                        end
                    end
                    dbba_pkg::OP_READ:
                    begin
                        done       = out_free;
                        res_track  = '0;
                        res_sector = '0;
                        res_bit    = '0;
                        res_row    = cmd_reg.cyl_ok ? dbba_pkg::ROWOUT_W'(row_eff) : '0;
                    end
                    default:
                    begin
                        done = out_free;
                    end
                endcase
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbba_pkg::B_IDLE;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= row_valid_reg[rd_addr];
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, memory write port and registered read port
    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop_valid && pop_ready)
        begin
            cmd_reg <= pop_cmd;
        end
        if (done)
        begin
            status_reg     <= res_status;
            cyl_out_reg    <= res_cyl;
            track_out_reg  <= res_track;
            sector_out_reg <= res_sector;
            bit_number_reg <= res_bit;
            row_bits_reg   <= res_row;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.cyl_out    = cyl_out_reg;
    assign rsp.track_out  = track_out_reg;
    assign rsp.sector_out = sector_out_reg;
    assign rsp.bit_number = bit_number_reg;
    assign rsp.row_bits   = row_bits_reg;

endmodule

>>> tb/sv/dbba_reply_checker.sv
// Channel monitor for the bitmap allocator: predicts each response beat and checks it.
`timescale 1ns / 1ps

module dbba_reply_checker
    import dbba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dbba_req_if  req,
    dbba_rsp_if  rsp,
    output int   mismatch_count,
    output int   replies_owed,
    output int   grants,
    output int   refusals,
    output int   rejected_frees,
    output int   row_reads
);

    localparam int ROW_W = TRACKS_PER_CYL_DEF * SECTORS_PER_TRACK_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CYL_W-1:0]    cyl;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [BITNUM_W-1:0] bitnum;
        logic [ROWOUT_W-1:0] row;
    } reply_t;

    logic [ROW_W-1:0] used_rows [CYLINDERS_DEF];
    reply_t           owed_replies [$];

    // Apply one request to the shadow map and return the reply it earns.
    function automatic reply_t bitmap_outcome(op_t op, logic [CYL_W-1:0] cyl,
                                              logic [TRACK_W-1:0] trk,
                                              logic [SECTOR_W-1:0] sec);
        reply_t r;
        int     bpos;
        logic   found;
        r     = '0;
        bpos  = SECTORS_PER_TRACK_DEF * int'(trk) + int'(sec);
        found = 1'b0;
        case (op)
            OP_MARK:
            begin
                used_rows[cyl][bpos] = 1'b1;
                r.status = ST_OK;
                r.cyl    = cyl;
                r.track  = trk;
                r.sector = sec;
                r.bitnum = BITNUM_W'(bpos);
            end
            OP_ALLOC:
            begin
                // first fit: lowest cylinder, then lowest bit number
                for (int c = 0; c < CYLINDERS_DEF; c++)
                begin
                    for (int b = 0; b < ROW_W; b++)
                    begin
                        if (!found && !used_rows[c][b])
                        begin
                            used_rows[c][b] = 1'b1;
                            found    = 1'b1;
                            r.cyl    = CYL_W'(c);
                            r.track  = TRACK_W'(b / SECTORS_PER_TRACK_DEF);
                            r.sector = SECTOR_W'(b % SECTORS_PER_TRACK_DEF);
                            r.bitnum = BITNUM_W'(b);
                        end
                    end
                end
                r.status = found ? ST_OK : ST_NO_FREE;
            end
            OP_FREE:
            begin
                if (used_rows[cyl][bpos])
                begin
                    used_rows[cyl][bpos] = 1'b0;
                    r.status = ST_OK;
                end
                else
                begin
                    r.status = ST_NOT_ALLOC;
                end
                r.cyl    = cyl;
                r.track  = trk;
                r.sector = sec;
                r.bitnum = BITNUM_W'(bpos);
            end
            default:
            begin
                r.status = ST_OK;
                r.cyl    = cyl;
                r.row    = ROWOUT_W'(used_rows[cyl]);
            end
        endcase
        return r;
    endfunction

    function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        int     bad;
        op_t    op;
        if (!rst_n)
        begin
            foreach (used_rows[c])
                used_rows[c] = '0;
            owed_replies.delete();
            mismatch_count <= 0;
            replies_owed   <= 0;
            grants         <= 0;
            refusals       <= 0;
            rejected_frees <= 0;
            row_reads      <= 0;
        end
        else
        begin
            bad = 0;
            // Retire the response beat first; it always belongs to an older request.
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got = {rsp.status, rsp.cyl_out, rsp.track_out, rsp.sector_out,
                       rsp.bit_number, rsp.row_bits};
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: response beat with none expected, actual %0h", $time, got);
                    bad = 1;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    bad += field_differs("status", 8'(want.status), 8'(got.status));
                    bad += field_differs("cyl_out", 8'(want.cyl), 8'(got.cyl));
                    bad += field_differs("track_out", 8'(want.track), 8'(got.track));
                    bad += field_differs("sector_out", 8'(want.sector), 8'(got.sector));
                    bad += field_differs("bit_number", 8'(want.bitnum), 8'(got.bitnum));
                    bad += field_differs("row_bits", want.row, got.row);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                op   = op_t'(req.opcode);
                want = bitmap_outcome(op, req.cyl_in, req.track_in, req.sector_in);
                owed_replies.push_back(want);
                if (op == OP_ALLOC && want.status == ST_OK)
                    grants <= grants + 1;
                if (op == OP_ALLOC && want.status == ST_NO_FREE)
                    refusals <= refusals + 1;
                if (op == OP_FREE && want.status == ST_NOT_ALLOC)
                    rejected_frees <= rejected_frees + 1;
                if (op == OP_READ)
                    row_reads <= row_reads + 1;
            end
            mismatch_count <= mismatch_count + bad;
            replies_owed   <= owed_replies.size();
        end
    end

endmodule

>>> tb/sv/tb_disk_block_bitmap_allocator_unit.sv
// Stimulus and verdict for the disk block bitmap allocator testbench.
`timescale 1ns / 1ps

module tb_disk_block_bitmap_allocator_unit;
    import dbba_pkg::*;

    // Roughly the random share of the run, on top of the directed opening.
    localparam int RANDOM_BEATS  = 1830;
    // Settling time after draining, with a comfortable margin over the longest allocate.
    localparam int SETTLE_CYCLES = 24;
    // Generous ceiling on the whole run.
    localparam int RUN_LIMIT_NS  = 5_000_000;
    // Long receiver hold-off: length and spacing, counted in receiver cycles.
    localparam int HOLD_LEN      = 200;
    localparam int HOLD_PERIOD   = 4000;
    localparam int HOLD_PHASE    = 1500;

    // Shapes of random traffic: which operations dominate a stretch of beats.
    typedef enum int { PH_FILL, PH_DRAIN, PH_HOTSPOT, PH_MIXED } phase_t;
    // Receiver behaviour over one stretch.
    typedef enum int { RM_ALWAYS, RM_COIN, RM_SPARSE, RM_PERIODIC } ready_mode_t;

    logic clk;
    logic rst_n;

    int mismatch_count;
    int replies_owed;
    int grants;
    int refusals;
    int rejected_frees;
    int row_reads;
    int burst_left;

    dbba_req_if req_ch ();
    dbba_rsp_if rsp_ch ();

    disk_block_bitmap_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Monitor sits beside the block, watching both channels.
    dbba_reply_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed),
        .grants         (grants),
        .refusals       (refusals),
        .rejected_frees (rejected_frees),
        .row_reads      (row_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one request beat and hold it until the block takes it.
    // Valid is left high so a back-to-back beat needs no extra assignment.
    task automatic offer_beat(input op_t op, input logic [CYL_W-1:0] cyl,
                              input logic [TRACK_W-1:0] trk,
                              input logic [SECTOR_W-1:0] sec);
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.cyl_in    <= cyl;
        req_ch.track_in  <= trk;
        req_ch.sector_in <= sec;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Drop valid and idle for a number of cycles.
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Burst pacing: beats come in bursts of random length, separated by gaps
    // that are usually short, sometimes absent, now and then long.
    task automatic pace_sender();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 24);
            roll       = $urandom_range(0, 15);
            if (roll < 4)
                hold_off(0);
            else if (roll == 15)
                hold_off($urandom_range(10, 30));
            else
                hold_off($urandom_range(1, 6));
        end
    endtask

    // Stop offering until every outstanding response beat has been seen.
    // The extra edge lets the monitor's count catch up with the last acceptance.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
    endtask

    task automatic random_beat(input phase_t phase, input int hot_top);
        int              roll;
        op_t             op;
        logic [CYL_W-1:0] cyl;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
                op = roll < 65 ? OP_ALLOC : roll < 80 ? OP_MARK : roll < 90 ? OP_FREE : OP_READ;
            PH_DRAIN:
                op = roll < 60 ? OP_FREE : roll < 75 ? OP_ALLOC : roll < 85 ? OP_MARK : OP_READ;
            PH_HOTSPOT:
                op = roll < 30 ? OP_ALLOC : roll < 60 ? OP_FREE : roll < 85 ? OP_MARK : OP_READ;
            default:
                op = roll < 25 ? OP_ALLOC : roll < 50 ? OP_FREE : roll < 75 ? OP_MARK : OP_READ;
        endcase
        // Drain and hotspot stretches aim at the low cylinders that first fit packs,
        // so frees mostly hit allocated blocks.
        if (phase == PH_DRAIN || phase == PH_HOTSPOT)
            cyl = CYL_W'($urandom_range(0, hot_top));
        else
            cyl = CYL_W'($urandom_range(0, CYLINDERS_DEF - 1));
        offer_beat(op, cyl, TRACK_W'($urandom_range(0, 1)), SECTOR_W'($urandom_range(0, 3)));
    endtask

    // Receiver: stalls on a pattern of its own, changing mode after each span of random
    // length, with a long hold-off now and then so the block backs up and
    // deasserts ready on the request side.
    initial
    begin : reply_sink
        ready_mode_t mode;
        int          span;
        int          cyc;
        int          hold_left;
        mode      = RM_ALWAYS;
        span      = 0;
        cyc       = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % HOLD_PERIOD == HOLD_PHASE)
                hold_left = HOLD_LEN;
            if (span == 0)
            begin
                mode = ready_mode_t'($urandom_range(0, 3));
                span = $urandom_range(40, 400);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RM_ALWAYS:   rsp_ch.ready <= 1'b1;
                    RM_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RM_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:     rsp_ch.ready <= (cyc % 5 < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        phase_t phase;
        int     phase_len;
        int     hot_top;
        int     random_sent;
        random_sent = 0;
        burst_left  = 0;

        // Hold every input at a known value from time zero.
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_MARK;
        req_ch.cyl_in    <= '0;
        req_ch.track_in  <= '0;
        req_ch.sector_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty map, freeing a free block, re-marking a used
        // block, field extremes, first fit across a row boundary, refilling a hole.
        offer_beat(OP_READ, 3'd0, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_FREE, 3'd0, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_MARK, 3'd0, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_MARK, 3'd0, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_ALLOC, 3'd7, 1'b1, 2'd3);   pace_sender();
        offer_beat(OP_MARK, 3'd7, 1'b1, 2'd3);    pace_sender();
        offer_beat(OP_READ, 3'd7, 1'b1, 2'd3);    pace_sender();
        offer_beat(OP_FREE, 3'd7, 1'b1, 2'd3);    pace_sender();
        offer_beat(OP_FREE, 3'd7, 1'b1, 2'd3);    pace_sender();
        // Fill the rest of cylinder 0 and spill one block into cylinder 1.
        repeat (7)
        begin
            offer_beat(OP_ALLOC, CYL_W'($urandom_range(0, 7)), TRACK_W'($urandom_range(0, 1)),
                       SECTOR_W'($urandom_range(0, 3)));
            pace_sender();
        end
        offer_beat(OP_READ, 3'd0, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_FREE, 3'd0, 1'b1, 2'd2);    pace_sender();
        offer_beat(OP_ALLOC, 3'd0, 1'b0, 2'd0);   pace_sender();
        offer_beat(OP_READ, 3'd1, 1'b0, 2'd0);    pace_sender();
        offer_beat(OP_FREE, 3'd3, 1'b0, 2'd1);    pace_sender();
        offer_beat(OP_MARK, 3'd5, 1'b1, 2'd3);    pace_sender();
        offer_beat(OP_READ, 3'd5, 1'b0, 2'd0);    pace_sender();

        // Pause the sender until the opening has fully drained.
        wait_drained();

        // Random stretches of fill, drain, hotspot and mixed traffic; fill
        // stretches run the map full so allocates get refused.
        while (random_sent < RANDOM_BEATS)
        begin
            phase     = phase_t'($urandom_range(0, 3));
            phase_len = $urandom_range(30, 150);
            hot_top   = $urandom_range(0, CYLINDERS_DEF - 1);
            for (int k = 0; k < phase_len && random_sent < RANDOM_BEATS; k++)
            begin
                random_beat(phase, hot_top);
                random_sent++;
                pace_sender();
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // Drain, then give the block time to put out anything stray.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d allocate grants, %0d refusals on a full map,", grants, refusals);
        $display("%0d frees of unallocated blocks and %0d row reads; %0d mismatches.",
                 rejected_frees, row_reads, mismatch_count);
        if (mismatch_count == 0 && replies_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        #RUN_LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/dbba_pkg.sv
sv/dbba_if.sv
sv/dbba_front.sv
sv/dbba_queue.sv
sv/dbba_back.sv
sv/disk_block_bitmap_allocator_unit.sv
tb/sv/dbba_reply_checker.sv
tb/sv/tb_disk_block_bitmap_allocator_unit.sv
